[rtl/core/mpow_pkg.sv]
// mpow_pkg: shared constants and types for the modular_power block.
// No dependencies.
package mpow_pkg;

   localparam int WORD_WIDTH = 16;
   localparam int CNT_W      = $clog2(WORD_WIDTH);

   localparam logic [WORD_WIDTH-1:0] MODULUS_RESET = WORD_WIDTH'(43 * 67);

   // request to the bit-serial modular multiplier
   typedef struct packed {
      logic                  start;
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
   } mm_req_type;

   // answer from the bit-serial modular multiplier
   typedef struct packed {
      logic                  done;
      logic [WORD_WIDTH-1:0] prod;
   } mm_rsp_type;

endpackage

[rtl/core/mpow_mulmod.sv]
// mpow_mulmod: bit-serial modular multiplier, a * b mod m, one multiplier bit per cycle.
// Requires a < m. Depends on mpow_pkg.
module mpow_mulmod import mpow_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WORD_WIDTH-1:0] modulus,
   input  mm_req_type            req,
   output mm_rsp_type            rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] a_ff, a_in;
   logic [WORD_WIDTH-1:0] b_ff, b_in;

   logic [WORD_WIDTH:0]   dbl, dbl_red, sum, sum_red;
   logic [WORD_WIDTH:0]   m_ext;

   // acc = 2*acc (+ a) mod m, both partial values stay below 2*m
   always_comb begin
      m_ext   = {1'b0, modulus};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
      sum     = dbl_red + (b_ff[WORD_WIDTH-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= m_ext) ? sum - m_ext : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (busy_ff) begin
         acc_in = sum_red[WORD_WIDTH-1:0];
         b_in   = {b_ff[WORD_WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_WIDTH - 1);
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

[rtl/core/mpow_seq.sv]
// mpow_seq: square-and-multiply sequencer over the exponent bits, MSB first.
// Drives mpow_mulmod for base reduction, squares and multiplies. Depends on mpow_pkg.
module mpow_seq import mpow_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WORD_WIDTH-1:0] modulus,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] base,
   input  logic [WORD_WIDTH-1:0] exponent,
   output logic                  idle,
   output logic                  res_valid,
   output logic [WORD_WIDTH-1:0] res_data,
   input  logic                  res_ack,
   output mm_req_type            mm_req,
   input  mm_rsp_type            mm_rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [WORD_WIDTH-1:0] exp_ff, exp_in;
   logic [WORD_WIDTH-1:0] base_ff, base_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  degenerate;

   assign degenerate = (modulus <= WORD_WIDTH'(1)) || (base == '0) || (exponent == '0);

   always_comb begin
      state_in = state_ff;
      exp_in   = exp_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      mm_req   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               exp_in = exponent;
               cnt_in = CNT_W'(WORD_WIDTH - 1);
               acc_in = WORD_WIDTH'(1);
               if (degenerate) begin
                  acc_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  mm_req.start = 1'b1;
                  mm_req.a     = WORD_WIDTH'(1);
                  mm_req.b     = base;
                  state_in     = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               base_in      = mm_rsp.prod;
               mm_req.start = 1'b1;
               mm_req.a     = acc_ff;
               mm_req.b     = acc_ff;
               state_in     = ST_SQUARE;
            end
         end
         ST_SQUARE, ST_MULT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.prod;
               if (state_ff == ST_SQUARE && exp_ff[WORD_WIDTH-1]) begin
                  mm_req.start = 1'b1;
                  mm_req.a     = mm_rsp.prod;
                  mm_req.b     = base_ff;
                  state_in     = ST_MULT;
               end else if (cnt_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in       = cnt_ff - 1'b1;
                  exp_in       = {exp_ff[WORD_WIDTH-2:0], 1'b0};
                  mm_req.start = 1'b1;
                  mm_req.a     = mm_rsp.prod;
                  mm_req.b     = mm_rsp.prod;
                  state_in     = ST_SQUARE;
               end
            end
         end
         ST_DONE: begin
            if (res_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      exp_ff  <= exp_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = acc_ff;

endmodule

[rtl/core/modular_power.sv]
// modular_power: base^exponent mod modulus by bit-serial square-and-multiply.
// The result is 0 by rule when modulus <= 1, base is 0 or exponent is 0; then no multiply runs.
// All modular multiplies run in the shared bit-serial multiplier; one item at a time.
// A new item is taken once the last one has left the sequencer, also while its result waits in the output register.
// Synchronous active-high reset; modulus register resets to 2881.
// Depends on mpow_pkg, mpow_mulmod, mpow_seq.
module modular_power import mpow_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*WORD_WIDTH-1:0] req_tdata,   // base, exponent
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [WORD_WIDTH-1:0]   rsp_tdata,   // power_mod
   input  logic                    csr_we,
   input  logic [WORD_WIDTH-1:0]   csr_wdata    // modulus
);

   logic [WORD_WIDTH-1:0] modulus_ff, modulus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                  seq_idle;
   logic                  res_valid;
   logic [WORD_WIDTH-1:0] res_data;
   logic                  res_ack;
   mm_req_type            mm_req;
   mm_rsp_type            mm_rsp;

   mpow_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .modulus   (modulus_ff),
      .start     (req_tvalid & req_tready),
      .base      (req_tdata[WORD_WIDTH-1:0]),
      .exponent  (req_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
      .idle      (seq_idle),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ack   (res_ack),
      .mm_req    (mm_req),
      .mm_rsp    (mm_rsp)
   );

   mpow_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .req     (mm_req),
      .rsp     (mm_rsp)
   );

   assign res_ack = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      modulus_in   = csr_we ? csr_wdata : modulus_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = seq_idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/mpow_checker.sv]
// mpow_checker: port-level checks for modular_power, bound to the top level.
// Depends on mpow_pkg.
module mpow_checker import mpow_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [2*WORD_WIDTH-1:0] req_tdata,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [WORD_WIDTH-1:0]   rsp_tdata,
   input logic                    csr_we,
   input logic [WORD_WIDTH-1:0]   csr_wdata
);

   logic [WORD_WIDTH-1:0] mod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
      end else if (csr_we) begin
         mod_ff <= csr_wdata;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata < mod_ff) || (rsp_tdata == '0))
      else $error("result not reduced modulo modulus");

endmodule

bind modular_power mpow_checker u_mpow_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we),
   .csr_wdata  (csr_wdata)
);
